// ----- design/dmxcc_pkg.sv -----
package dmxcc_pkg;

  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned INDEX_W    = 9;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    PHASE_IDLE    = 2'd0,
    PHASE_BREAK   = 2'd1,
    PHASE_SEEK    = 2'd2,
    PHASE_CAPTURE = 2'd3
  } phase_t;

  typedef struct packed {
    logic               frame_done;
    logic [DATA_W-1:0]  channel_value;
    logic [INDEX_W-1:0] channel_index;
  } result_t;

endpackage

// ----- design/dmxcc_fsm.sv -----
module dmxcc_fsm #(
  parameter int unsigned CHANNELS = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [dmxcc_pkg::DATA_W-1:0] rx_byte,
  input  logic                         framing_error,
  input  logic [dmxcc_pkg::SLOT_W-1:0] start_address,
  output logic                         res_valid,
  output dmxcc_pkg::result_t           res
);

  localparam logic [dmxcc_pkg::SLOT_W-1:0] CH_COUNT = dmxcc_pkg::SLOT_W'(CHANNELS);

  dmxcc_pkg::phase_t                phase;
  dmxcc_pkg::phase_t                phase_next;
  logic [dmxcc_pkg::SLOT_W-1:0]     slot_counter;
  logic [dmxcc_pkg::SLOT_W-1:0]     slot_counter_next;

  logic [dmxcc_pkg::SLOT_W-1:0]     slot_dec;
  logic [dmxcc_pkg::SLOT_W-1:0]     emit_idx;
  logic [dmxcc_pkg::SLOT_W-1:0]     emit_idx_inc;
  logic                             emit_last;
  logic                             emit_now;

  assign slot_dec     = slot_counter - dmxcc_pkg::SLOT_W'(1);
  assign emit_idx     = (phase == dmxcc_pkg::PHASE_CAPTURE) ? slot_counter
                                                            : '0;
  assign emit_idx_inc = emit_idx + dmxcc_pkg::SLOT_W'(1);
  assign emit_last    = (emit_idx_inc >= CH_COUNT);
  assign emit_now     = (phase == dmxcc_pkg::PHASE_CAPTURE) ||
                        ((phase == dmxcc_pkg::PHASE_SEEK) && (slot_dec == '0));

  // next state
  always_comb begin
    phase_next        = phase;
    slot_counter_next = slot_counter;
    if (accept) begin
      if (framing_error) begin
        phase_next = dmxcc_pkg::PHASE_BREAK;
      end else begin
        case (phase)
          dmxcc_pkg::PHASE_BREAK: begin
            if (rx_byte == '0) begin
              slot_counter_next = (start_address == '0) ? dmxcc_pkg::SLOT_W'(1)
                                                        : start_address;
              phase_next        = dmxcc_pkg::PHASE_SEEK;
            end else begin
              phase_next = dmxcc_pkg::PHASE_IDLE;
            end
          end
          dmxcc_pkg::PHASE_SEEK: begin
            slot_counter_next = slot_dec;
          end
          default: ;
        endcase
        if (emit_now) begin
          if (emit_last) begin
            phase_next        = dmxcc_pkg::PHASE_IDLE;
            slot_counter_next = '0;
          end else begin
            phase_next        = dmxcc_pkg::PHASE_CAPTURE;
            slot_counter_next = emit_idx_inc;
          end
        end
      end
    end
  end

  // result
  always_comb begin
    res_valid         = accept && !framing_error && emit_now;
    res.channel_index = emit_idx[dmxcc_pkg::INDEX_W-1:0];
    res.channel_value = rx_byte;
    res.frame_done    = emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= dmxcc_pkg::PHASE_IDLE;
      slot_counter <= '0;
    end else begin
      phase        <= phase_next;
      slot_counter <= slot_counter_next;
    end
  end

`ifndef SYNTH
  a_capture_index: assert property (@(posedge clk) disable iff (rst)
    phase == dmxcc_pkg::PHASE_CAPTURE |-> (slot_counter != '0) && (slot_counter < CH_COUNT))
    else $error("capture index out of range");

  a_break_wins: assert property (@(posedge clk) disable iff (rst)
    accept && framing_error |=> phase == dmxcc_pkg::PHASE_BREAK)
    else $error("break did not restart the frame");

  a_seek_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == dmxcc_pkg::PHASE_SEEK |-> slot_counter != '0)
    else $error("slot counter empty while seeking");
`endif

endmodule

// ----- design/dmx512_channel_capture_core.sv -----
// DMX512 channel capture. Each transfer on the s_ side carries one received UART byte and its
// framing-error flag (a break). After a break a zero start code arms the receiver, which then
// skips slots up to start_address and emits CHANNELS channel bytes with their index; the last
// one has tlast set. A byte is taken every clock while s_tready is high; its channel, if any, is
// registered into the output entry, or into the skid entry while the m_ side stalls. A two-entry
// output buffer keeps input and output apart, so s_tready drops only when both entries are
// held by a stalled m_ side. The user is to write start_address through cfg_* only while the block
// is idle, which the block does not enforce; start_address is sampled on each zero start code.
module dmx512_channel_capture_core #(
  parameter int unsigned CHANNELS = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // rx_byte
  input  logic                              s_tuser,   // framing_error
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [dmxcc_pkg::OUT_TDATA_W-1:0] m_tdata,   // channel_index, channel_value, zeros
  output logic                              m_tlast,   // frame_done
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dmxcc_pkg::SLOT_W-1:0]      cfg_data
);

  localparam int unsigned PAD_W = dmxcc_pkg::OUT_TDATA_W - dmxcc_pkg::INDEX_W
                                  - dmxcc_pkg::DATA_W;

  logic [dmxcc_pkg::SLOT_W-1:0] start_address;
  logic                         in_accept;
  logic                         res_valid;
  dmxcc_pkg::result_t           res;

  logic                         out_valid;
  dmxcc_pkg::result_t           out_data;
  logic                         skid_valid;
  dmxcc_pkg::result_t           skid_data;
  logic                         out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= dmxcc_pkg::SLOT_W'(1);
    end else if (cfg_valid) begin
      start_address <= cfg_data;
    end
  end

  assign s_tready  = !skid_valid;
  assign in_accept = s_tvalid && s_tready;

  dmxcc_fsm #(
    .CHANNELS (CHANNELS)
  ) u_fsm (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .rx_byte       (s_tdata),
    .framing_error (s_tuser),
    .start_address (start_address),
    .res_valid     (res_valid),
    .res           (res)
  );

  // output register plus skid entry
  assign out_free = m_tready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : res;
    end
    if (!out_free && res_valid) begin
      skid_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_data.channel_value, out_data.channel_index};
  assign m_tlast  = out_data.frame_done;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without output entry");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, out_data.channel_index} < dmxcc_pkg::SLOT_W'(CHANNELS)))
    else $error("channel index beyond channel count");

  a_last_matches_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == ({1'b0, out_data.channel_index} ==
                              dmxcc_pkg::SLOT_W'(CHANNELS - 1))))
    else $error("frame end flag does not match channel index");
`endif

endmodule

// ----- dv/dmx512_channel_capture_core_tb.sv -----
module dmx512_channel_capture_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHANNELS = 9;
  localparam int unsigned ITEMS = 1550;
  localparam int unsigned LIMIT = 500000;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;   // rx_byte
  logic s_tuser;         // framing_error
  logic m_tvalid;
  logic m_tready;
  logic [dmxcc_pkg::OUT_TDATA_W-1:0] m_tdata;   // channel_index, channel_value, zeros
  logic m_tlast;                                // frame_done
  logic cfg_valid;
  logic cfg_ready;
  logic [dmxcc_pkg::SLOT_W-1:0] cfg_data;

  int unsigned cycles;
  int unsigned slots_sent;
  int unsigned addr_settings;
  bit tx_steady;
  bit rx_steady;

  class dmx_capture_tracker;
    dmxcc_pkg::phase_t phase;
    logic [dmxcc_pkg::SLOT_W-1:0] slots_left;
    logic [dmxcc_pkg::SLOT_W-1:0] start_addr;
    dmxcc_pkg::result_t due_channels[$];
    int unsigned errors;
    int unsigned breaks;
    int unsigned channels;
    int unsigned frames;

    function new();
      phase = dmxcc_pkg::PHASE_IDLE;
      slots_left = '0;
      start_addr = dmxcc_pkg::SLOT_W'(1);
    endfunction

    function void set_start_address(logic [dmxcc_pkg::SLOT_W-1:0] value);
      start_addr = value;
    endfunction

    function int pending();
      return due_channels.size();
    endfunction

    function void push_channel(int unsigned idx, logic [7:0] value);
      dmxcc_pkg::result_t r;
      r.channel_index = idx[dmxcc_pkg::INDEX_W-1:0];
      r.channel_value = value;
      r.frame_done = (idx + 1 >= CHANNELS);
      due_channels.push_back(r);
      channels++;
      if (r.frame_done) begin
        phase = dmxcc_pkg::PHASE_IDLE;
        slots_left = '0;
        frames++;
      end else begin
        phase = dmxcc_pkg::PHASE_CAPTURE;
        slots_left = dmxcc_pkg::SLOT_W'(idx + 1);
      end
    endfunction

    function void take_slot(logic [7:0] rx_byte, logic framing_error);
      if (framing_error) begin
        phase = dmxcc_pkg::PHASE_BREAK;
        breaks++;
        return;
      end
      case (phase)
        dmxcc_pkg::PHASE_BREAK: begin
          if (rx_byte == 8'h00) begin
            slots_left = (start_addr == '0) ? dmxcc_pkg::SLOT_W'(1) : start_addr;
            phase = dmxcc_pkg::PHASE_SEEK;
          end else begin
            phase = dmxcc_pkg::PHASE_IDLE;
          end
        end
        dmxcc_pkg::PHASE_SEEK: begin
          slots_left = slots_left - dmxcc_pkg::SLOT_W'(1);
          if (slots_left == '0) push_channel(0, rx_byte);
        end
        dmxcc_pkg::PHASE_CAPTURE: push_channel(slots_left, rx_byte);
        default: ;
      endcase
    endfunction

    function void check_channel(dmxcc_pkg::result_t got);
      dmxcc_pkg::result_t want;
      if (due_channels.size() == 0) begin
        $error("channel transfer with nothing expected: index %0d value %0d done %0d",
               got.channel_index, got.channel_value, got.frame_done);
        errors++;
        return;
      end
      want = due_channels.pop_front();
      if (got.channel_index !== want.channel_index) begin
        $error("channel_index: expected %0d, got %0d", want.channel_index, got.channel_index);
        errors++;
      end
      if (got.channel_value !== want.channel_value) begin
        $error("channel_value: expected %0d, got %0d", want.channel_value, got.channel_value);
        errors++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
        errors++;
      end
    endfunction
  endclass

  dmx_capture_tracker tracker = new();

  dmx512_channel_capture_core #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_channel({m_tlast, m_tdata[16:0]});
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // output side back-pressure
  initial begin
    int unsigned stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = rx_steady ? 0 : idle_len();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_slot(logic [7:0] rx_byte, logic framing_error);
    int unsigned gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= rx_byte;
    s_tuser <= framing_error;
    do @(posedge clk); while (!s_tready);
    tracker.take_slot(rx_byte, framing_error);
    slots_sent++;
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_start_address(logic [dmxcc_pkg::SLOT_W-1:0] value);
    wait_results_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_start_address(value);
    addr_settings++;
  endtask

  task automatic send_frame(int unsigned addr);
    int unsigned n_breaks;
    int unsigned n_slots;
    logic [7:0] code;
    if ($urandom_range(0, 9) == 0) begin
      // noise, breaks sprinkled at random
      repeat ($urandom_range(1, 6))
        send_slot(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end else begin
      n_breaks = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
      repeat (n_breaks) send_slot(8'($urandom_range(0, 255)), 1'b1);
      code = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      send_slot(code, 1'b0);
      n_slots = addr - 1 + CHANNELS + $urandom_range(0, 3);
      // cut short, so the next break lands mid-frame
      if ($urandom_range(0, 6) == 0) n_slots = $urandom_range(0, n_slots);
      repeat (n_slots) send_slot(8'($urandom_range(0, 255)), 1'b0);
    end
    if ($urandom_range(0, 29) == 0) wait_results_drained();
  endtask

  initial begin
    int unsigned addr;
    int unsigned phase_no;
    int unsigned phase_end;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    cycles <= 0;
    slots_sent = 0;
    addr_settings = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed frames
    write_start_address(dmxcc_pkg::SLOT_W'(1));
    send_slot(8'hff, 1'b0);
    send_slot(8'h00, 1'b1);
    send_slot(8'hff, 1'b1);
    send_slot(8'h55, 1'b0);
    send_slot(8'h00, 1'b0);
    send_slot(8'h00, 1'b1);
    send_slot(8'h00, 1'b0);
    send_slot(8'h00, 1'b0);
    send_slot(8'hff, 1'b0);
    send_slot(8'haa, 1'b0);
    send_slot(8'h55, 1'b0);
    for (int i = 0; i < CHANNELS - 4; i++) send_slot(8'h01 << (i % 8), 1'b0);
    send_slot(8'h80, 1'b0);
    send_slot(8'h00, 1'b1);
    send_slot(8'h00, 1'b0);
    send_slot(8'h12, 1'b0);
    send_slot(8'h34, 1'b0);
    send_slot(8'hff, 1'b1);
    send_slot(8'h01, 1'b0);

    // random frames over a series of start addresses
    phase_no = 0;
    while (slots_sent < ITEMS) begin
      case (phase_no)
        0: addr = 512;
        1: addr = 1;
        2: addr = CHANNELS;
        default: addr = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 512)
                                                     : $urandom_range(1, 24);
      endcase
      write_start_address(dmxcc_pkg::SLOT_W'(addr));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      phase_end = slots_sent + 150;
      while (slots_sent < phase_end && slots_sent < ITEMS) send_frame(addr);
      phase_no++;
    end

    wait_results_drained();
    rx_steady = 1'b0;
    repeat (8) @(posedge clk);
    $display("sent %0d slots with %0d breaks over %0d start address settings",
             slots_sent, tracker.breaks, addr_settings);
    $display("checked %0d captured channels in %0d complete frames",
             tracker.channels, tracker.frames);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/dmxcc_pkg.sv
design/dmxcc_fsm.sv
design/dmx512_channel_capture_core.sv
dv/dmx512_channel_capture_core_tb.sv
